[hdl/eco_pkg.sv]
// Shared constants and helpers for the Euler camera orientation core.
package eco_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int VEC_FRAC_BITS   = 13;
  localparam int CORDIC_STEPS    = 16;

  // Angle constants in degrees * 2^ANGLE_FRAC_BITS
  localparam int HALF_TURN    = 180 << ANGLE_FRAC_BITS;
  localparam int QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int FULL_TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int PITCH_LIMIT_RESET = 89 << ANGLE_FRAC_BITS;

  localparam int VEC_ONE   = 1 << VEC_FRAC_BITS;
  localparam int CORDIC_K  = 652032874;  // 0.607252935 in Q30
  localparam int POS_Z_RESET = 768;

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  typedef logic signed [32:0] cq_t;   // CORDIC x/y, Q30
  typedef logic signed [31:0] cz_t;   // CORDIC angle, degrees * 2^20
  typedef logic signed [15:0] vec_t;

  // atan(2^-i) in degrees * 2^20
  function automatic cz_t atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 32'sd47185920;
      5'd1:  atan_deg = 32'sd27855475;
      5'd2:  atan_deg = 32'sd14718068;
      5'd3:  atan_deg = 32'sd7471121;
      5'd4:  atan_deg = 32'sd3750058;
      5'd5:  atan_deg = 32'sd1876857;
      5'd6:  atan_deg = 32'sd938658;
      5'd7:  atan_deg = 32'sd469357;
      5'd8:  atan_deg = 32'sd234682;
      5'd9:  atan_deg = 32'sd117342;
      5'd10: atan_deg = 32'sd58671;
      5'd11: atan_deg = 32'sd29335;
      5'd12: atan_deg = 32'sd14668;
      5'd13: atan_deg = 32'sd7334;
      5'd14: atan_deg = 32'sd3667;
      5'd15: atan_deg = 32'sd1833;
      5'd16: atan_deg = 32'sd917;
      5'd17: atan_deg = 32'sd458;
      5'd18: atan_deg = 32'sd229;
      5'd19: atan_deg = 32'sd115;
      5'd20: atan_deg = 32'sd57;
      5'd21: atan_deg = 32'sd29;
      5'd22: atan_deg = 32'sd14;
      5'd23: atan_deg = 32'sd7;
      default: atan_deg = 32'sd0;
    endcase
  endfunction

  // Q30 to vector format, round half up, clamp to +-1.0
  function automatic vec_t to_vec(input logic signed [33:0] q);
    logic signed [33:0] r;
    r = (q + (34'sd1 <<< (29 - VEC_FRAC_BITS))) >>> (30 - VEC_FRAC_BITS);
    if (r > 34'(VEC_ONE))       to_vec = 16'(VEC_ONE);
    else if (r < -34'(VEC_ONE)) to_vec = -16'(VEC_ONE);
    else                        to_vec = r[15:0];
  endfunction

  // Product round half up, then saturate to 16 bits
  function automatic vec_t rnd_sat(input logic signed [35:0] p);
    logic signed [35:0] r;
    r = (p + (36'sd1 <<< (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS;
    if (r > 36'sd32767)       rnd_sat = 16'sh7fff;
    else if (r < -36'sd32768) rnd_sat = 16'sh8000;
    else                      rnd_sat = r[15:0];
  endfunction

endpackage

[hdl/euler_camera_orientation_core.sv]
// Euler camera core: position, yaw/pitch and basis rebuilt by a shared CORDIC and multiplier.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  cfg     | cfg_valid / cfg_ready  | pitch_limit
//  in      | in_valid / in_ready    | delta_pitch, delta_yaw, move_x/y/z
//  out     | out_valid / out_ready  | position_x/y/z, forward_*, right_*, up_*
//
// An item with both angle deltas zero goes from acceptance straight to S_FINISH for the
// result load; otherwise the basis is rebuilt by one CORDIC rotator used for yaw then
// pitch and one 17x17 multiplier used for six products in turn. in_ready returns the
// cycle after the result is loaded.
// Synchronous reset loads the home pose. in_ready is high only while idle; a finished
// result waits in the output registers while the next item is already accepted, and the
// next result load stalls until that result is taken. cfg_ready is always high.
module euler_camera_orientation_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [12:0] pitch_limit,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [13:0] delta_pitch,
  input  logic signed [13:0] delta_yaw,
  input  logic signed [15:0] move_x,
  input  logic signed [15:0] move_y,
  input  logic signed [15:0] move_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] position_x,
  output logic signed [23:0] position_y,
  output logic signed [23:0] position_z,
  output logic signed [15:0] forward_x,
  output logic signed [15:0] forward_y,
  output logic signed [15:0] forward_z,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROT, S_SAVE, S_MUL, S_FINISH} state_t;

  state_t state;
  logic [12:0] limit;
  logic signed [14:0] yaw;
  logic signed [13:0] pitch;
  logic signed [23:0] pos [3];
  eco_pkg::vec_t fwd_x, fwd_y, fwd_z, rgt_x, rgt_z, upv_x, upv_y, upv_z;

  // CORDIC and product datapath registers
  eco_pkg::cq_t cx, cy;
  eco_pkg::cz_t cz;
  logic [eco_pkg::ITER_W-1:0] iter;
  logic pass;       // 0: yaw, 1: pitch
  logic neg_cos;
  eco_pkg::vec_t sin_yaw, cos_yaw, cos_pit;
  logic [2:0] mstep;
  logic signed [33:0] prod;
  logic signed [35:0] acc;

  logic in_fire;
  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Position accumulate with saturation
  logic signed [23:0] pos_next [3];
  logic signed [15:0] moves [3];
  assign moves[0] = move_x;
  assign moves[1] = move_y;
  assign moves[2] = move_z;
  always_comb begin
    logic signed [24:0] s;
    for (int k = 0; k < 3; k++) begin
      s = 25'(pos[k]) + 25'(moves[k]);
      if (s > 25'sd8388607)       pos_next[k] = 24'sh7fffff;
      else if (s < -25'sd8388608) pos_next[k] = 24'sh800000;
      else                        pos_next[k] = s[23:0];
    end
  end

  // Yaw wrap and pitch clamp
  logic signed [14:0] yaw_next;
  logic signed [13:0] pitch_next;
  always_comb begin
    logic signed [16:0] t;
    logic signed [15:0] p;
    logic signed [15:0] lim;
    t = 17'(yaw) + 17'(delta_yaw) + 17'(eco_pkg::HALF_TURN);
    if (t < 17'sd0) t = t + 17'(eco_pkg::FULL_TURN);
    else if (t >= 17'(eco_pkg::FULL_TURN)) t = t - 17'(eco_pkg::FULL_TURN);
    yaw_next = 15'(t - 17'(eco_pkg::HALF_TURN));
    lim = 16'($unsigned(limit));
    p = 16'(pitch) + 16'(delta_pitch);
    if (p > lim && delta_pitch > 14'sd0)       p = lim;
    else if (p < -lim && delta_pitch < 14'sd0) p = -lim;
    if (p > 16'sd8191)       pitch_next = 14'sh1fff;
    else if (p < -16'sd8192) pitch_next = 14'sh2000;
    else                     pitch_next = p[13:0];
  end

  // Angle fold into [-90, 90] for the rotator
  logic signed [15:0] fold_a;
  logic fold_neg;
  always_comb begin
    logic signed [15:0] a;
    a = pass ? 16'(pitch) : 16'(yaw);
    fold_neg = 1'b0;
    fold_a = a;
    if (a > 16'(eco_pkg::QUARTER_TURN)) begin
      fold_a = 16'(eco_pkg::HALF_TURN) - a;
      fold_neg = 1'b1;
    end else if (a < -16'(eco_pkg::QUARTER_TURN)) begin
      fold_a = -16'(eco_pkg::HALF_TURN) - a;
      fold_neg = 1'b1;
    end
  end

  // One CORDIC micro-rotation
  eco_pkg::cq_t rx_next, ry_next;
  eco_pkg::cz_t rz_next;
  always_comb begin
    eco_pkg::cq_t dx, dy;
    eco_pkg::cz_t at;
    dx = cy >>> iter;
    dy = cx >>> iter;
    at = eco_pkg::atan_deg(5'(iter));
    if (cz >= 32'sd0) begin
      rx_next = cx - dx; ry_next = cy + dy; rz_next = cz - at;
    end else begin
      rx_next = cx + dx; ry_next = cy - dy; rz_next = cz + at;
    end
  end

  // Shared multiplier operand select
  logic signed [16:0] op_a, op_b;
  always_comb begin
    case (mstep)
      3'd0:    begin op_a = 17'(cos_yaw); op_b = 17'(cos_pit); end
      3'd1:    begin op_a = 17'(sin_yaw); op_b = 17'(cos_pit); end
      3'd2:    begin op_a = -17'(fwd_x);  op_b = 17'(fwd_y);   end
      3'd3:    begin op_a = 17'(fwd_x);   op_b = 17'(fwd_x);   end
      3'd4:    begin op_a = 17'(fwd_z);   op_b = 17'(fwd_z);   end
      3'd5:    begin op_a = -17'(fwd_z);  op_b = 17'(fwd_y);   end
      default: begin op_a = '0;           op_b = '0;           end
    endcase
  end

  // Sequencer, stores and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      limit <= 13'(eco_pkg::PITCH_LIMIT_RESET);
      yaw   <= -15'(eco_pkg::HALF_TURN);
      pitch <= '0;
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= 24'(eco_pkg::POS_Z_RESET);
      fwd_x <= '0;
      fwd_y <= '0;
      fwd_z <= -16'(eco_pkg::VEC_ONE);
      rgt_x <= 16'(eco_pkg::VEC_ONE);
      rgt_z <= '0;
      upv_x <= '0;
      upv_y <= 16'(eco_pkg::VEC_ONE);
      upv_z <= '0;
      out_valid <= 1'b0;
      pass <= 1'b0;
      iter <= '0;
      mstep <= '0;
    end else begin
      if (cfg_valid && cfg_ready) limit <= pitch_limit;
      // a result load in S_FINISH sets valid again
      if (out_valid && out_ready && state != S_FINISH) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            for (int k = 0; k < 3; k++) pos[k] <= pos_next[k];
            if (delta_pitch != 14'sd0 || delta_yaw != 14'sd0) begin
              yaw   <= yaw_next;
              pitch <= pitch_next;
              pass  <= 1'b0;
              state <= S_LOAD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_LOAD: begin
          cx <= 33'(eco_pkg::CORDIC_K);
          cy <= '0;
          cz <= 32'(fold_a) <<< (20 - eco_pkg::ANGLE_FRAC_BITS);
          neg_cos <= fold_neg;
          iter <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cx <= rx_next;
          cy <= ry_next;
          cz <= rz_next;
          if (iter == eco_pkg::ITER_W'(eco_pkg::CORDIC_STEPS - 1)) state <= S_SAVE;
          else iter <= iter + 1'b1;
        end
        S_SAVE: begin
          if (!pass) begin
            cos_yaw <= eco_pkg::to_vec(neg_cos ? -34'(cx) : 34'(cx));
            sin_yaw <= eco_pkg::to_vec(34'(cy));
            pass  <= 1'b1;
            state <= S_LOAD;
          end else begin
            cos_pit <= eco_pkg::to_vec(neg_cos ? -34'(cx) : 34'(cx));
            fwd_y   <= eco_pkg::to_vec(34'(cy));
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= op_a * op_b;
          mstep <= mstep + 1'b1;
          case (mstep)
            3'd1: fwd_x <= eco_pkg::rnd_sat(36'(prod));
            3'd2: fwd_z <= eco_pkg::rnd_sat(36'(prod));
            3'd3: upv_x <= eco_pkg::rnd_sat(36'(prod));
            3'd4: acc   <= 36'(prod);
            3'd5: upv_y <= eco_pkg::rnd_sat(acc + 36'(prod));
            3'd6: begin
              upv_z <= eco_pkg::rnd_sat(36'(prod));
              rgt_x <= (fwd_z == 16'sh8000) ? 16'sh7fff : -fwd_z;
              rgt_z <= fwd_x;
              state <= S_FINISH;
            end
            default: ;
          endcase
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            position_x <= pos[0];
            position_y <= pos[1];
            position_z <= pos[2];
            forward_x <= fwd_x;
            forward_y <= fwd_y;
            forward_z <= fwd_z;
            right_x <= rgt_x;
            right_y <= '0;
            right_z <= rgt_z;
            up_x <= upv_x;
            up_y <= upv_y;
            up_z <= upv_z;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    yaw >= -15'(eco_pkg::HALF_TURN) && yaw < 15'(eco_pkg::HALF_TURN))
    else $error("yaw out of wrap range");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("accepted item did not make the core busy");
  a_mstep_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> mstep <= 3'd6)
    else $error("multiplier step overrun");
  a_up_y_sign: assert property (@(posedge clk) disable iff (rst)
    !upv_y[15])
    else $error("up_y negative");

endmodule

[tb/sv/testbench.sv]
// Testbench for the Euler camera orientation core: random and directed moves checked against a predictor.
`timescale 1ns / 100ps

module testbench;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic        [12:0] pitch_limit;
  logic               in_valid;
  logic               in_ready;
  logic signed [13:0] delta_pitch;
  logic signed [13:0] delta_yaw;
  logic signed [15:0] move_x;
  logic signed [15:0] move_y;
  logic signed [15:0] move_z;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] position_x, position_y, position_z;
  logic signed [15:0] forward_x, forward_y, forward_z;
  logic signed [15:0] right_x, right_y, right_z;
  logic signed [15:0] up_x, up_y, up_z;

  typedef struct {
    logic signed [23:0] pos [3];
    logic signed [15:0] fwd [3];
    logic signed [15:0] rgt [3];
    logic signed [15:0] upv [3];
  } pose_t;

  int errors = 0;
  longint cycles = 0;
  bit stim_done = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Pose predictor and store of expected poses
  class pose_scoreboard;
    longint limit_deg;
    longint yaw, pitch;
    longint pos [3];
    longint fwd [3];
    longint rgt [3];
    longint upv [3];
    pose_t pending [$];

    function new();
      limit_deg = eco_pkg::PITCH_LIMIT_RESET;
      yaw = -eco_pkg::HALF_TURN;
      pitch = 0;
      pos = '{0, 0, eco_pkg::POS_Z_RESET};
      fwd = '{0, 0, -eco_pkg::VEC_ONE};
      rgt = '{eco_pkg::VEC_ONE, 0, 0};
      upv = '{0, eco_pkg::VEC_ONE, 0};
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint q30_to_vec(longint q);
      return clip((q + (64'sd1 <<< (29 - eco_pkg::VEC_FRAC_BITS))) >>>
                  (30 - eco_pkg::VEC_FRAC_BITS), -eco_pkg::VEC_ONE, eco_pkg::VEC_ONE);
    endfunction

    function longint round_prod(longint p);
      return clip((p + (64'sd1 <<< (eco_pkg::VEC_FRAC_BITS - 1))) >>> eco_pkg::VEC_FRAC_BITS,
                  -32768, 32767);
    endfunction

    function void sin_cos(input longint a, output longint s, output longint c);
      longint x, y, z, dx, dy;
      longint steps [24];
      bit flip;
      steps = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                917, 458, 229, 115, 57, 29, 14, 7};
      flip = 0;
      if (a > eco_pkg::QUARTER_TURN) begin
        a = eco_pkg::HALF_TURN - a;
        flip = 1;
      end else if (a < -eco_pkg::QUARTER_TURN) begin
        a = -eco_pkg::HALF_TURN - a;
        flip = 1;
      end
      x = eco_pkg::CORDIC_K;
      y = 0;
      z = a <<< (20 - eco_pkg::ANGLE_FRAC_BITS);
      for (int i = 0; i < eco_pkg::CORDIC_STEPS && i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= steps[i];
        end else begin
          x += dx; y -= dy; z += steps[i];
        end
      end
      c = q30_to_vec(flip ? -x : x);
      s = q30_to_vec(y);
    endfunction

    function void note_move(input longint dp, input longint dy, input longint m [3]);
      longint r, sy, cy, sp, cp, fx, fy, fz;
      pose_t p;
      for (int k = 0; k < 3; k++)
        pos[k] = clip(pos[k] + m[k], -8388608, 8388607);
      if (dp != 0 || dy != 0) begin
        r = ((yaw + dy + eco_pkg::HALF_TURN) % eco_pkg::FULL_TURN + eco_pkg::FULL_TURN)
            % eco_pkg::FULL_TURN;
        yaw = r - eco_pkg::HALF_TURN;
        pitch += dp;
        if (pitch > limit_deg && dp > 0) pitch = limit_deg;
        else if (pitch < -limit_deg && dp < 0) pitch = -limit_deg;
        pitch = clip(pitch, -8192, 8191);
        sin_cos(yaw, sy, cy);
        sin_cos(pitch, sp, cp);
        fx = round_prod(cy * cp);
        fy = clip(sp, -32768, 32767);
        fz = round_prod(sy * cp);
        fwd = '{fx, fy, fz};
        rgt = '{clip(-fz, -32768, 32767), 0, fx};
        upv = '{round_prod(-fx * fy), round_prod(fx * fx + fz * fz), round_prod(-fz * fy)};
      end
      for (int k = 0; k < 3; k++) begin
        p.pos[k] = 24'(pos[k]);
        p.fwd[k] = 16'(fwd[k]);
        p.rgt[k] = 16'(rgt[k]);
        p.upv[k] = 16'(upv[k]);
      end
      pending.push_back(p);
    endfunction

    task check_pose(input pose_t got);
      pose_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 3; k++) begin
        if (got.pos[k] !== want.pos[k])
          report($sformatf("position[%0d]", k), got.pos[k], want.pos[k]);
        if (got.fwd[k] !== want.fwd[k])
          report($sformatf("forward[%0d]", k), got.fwd[k], want.fwd[k]);
        if (got.rgt[k] !== want.rgt[k])
          report($sformatf("right[%0d]", k), got.rgt[k], want.rgt[k]);
        if (got.upv[k] !== want.upv[k])
          report($sformatf("up[%0d]", k), got.upv[k], want.upv[k]);
      end
    endtask
  endclass

  pose_scoreboard pose_sb = new();

  euler_camera_orientation_core u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pitch_limit(pitch_limit),
    .in_valid(in_valid), .in_ready(in_ready),
    .delta_pitch(delta_pitch), .delta_yaw(delta_yaw),
    .move_x(move_x), .move_y(move_y), .move_z(move_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .position_x(position_x), .position_y(position_y), .position_z(position_z),
    .forward_x(forward_x), .forward_y(forward_y), .forward_z(forward_z),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z)
  );

  // Clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Mostly short gaps, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  task automatic write_limit(input logic [12:0] v);
    cfg_valid <= 1;
    pitch_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    pose_sb.limit_deg = v;
    cfg_valid <= 0;
  endtask

  // in_valid stays high after the accept; send_gap or drain drops it
  task automatic send_move(input logic signed [13:0] dp, input logic signed [13:0] dy,
                           input logic signed [15:0] mx, input logic signed [15:0] my,
                           input logic signed [15:0] mz);
    longint m [3];
    in_valid <= 1;
    delta_pitch <= dp;
    delta_yaw <= dy;
    move_x <= mx;
    move_y <= my;
    move_z <= mz;
    do @(posedge clk); while (!in_ready);
    m = '{mx, my, mz};
    pose_sb.note_move(dp, dy, m);
  endtask

  task automatic send_gap();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pose_sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_move(input bit turn_heavy);
    logic signed [13:0] dp, dy;
    logic signed [15:0] m [3];
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      dp = '0; dy = '0;
    end else if (turn_heavy && pick < 7) begin
      dp = 14'($signed(14'($urandom_range(0, 1023))) - 512);
      dy = 14'($signed(14'($urandom_range(0, 2047))) - 1024);
    end else begin
      dp = 14'($urandom);
      dy = 14'($urandom);
    end
    for (int k = 0; k < 3; k++)
      m[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                        : 16'($signed(16'($urandom_range(0, 511))) - 256);
    send_move(dp, dy, m[0], m[1], m[2]);
  endtask

  // Stimulus
  initial begin
    logic [12:0] limits [5];
    limits = '{13'd0, 13'd5760, 13'd2880, 13'd8191, 13'd5696};
    rst <= 1;
    cfg_valid <= 0;
    pitch_limit <= '0;
    in_valid <= 0;
    delta_pitch <= '0;
    delta_yaw <= '0;
    move_x <= '0;
    move_y <= '0;
    move_z <= '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: no turn, extremes, wraps, clamp edges, position saturation
    send_move(0, 0, 0, 0, 0);
    send_move(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_move(14'sh1fff, 14'sh1fff, 0, 0, 0);
    send_move(14'sh2000, 14'sh2000, 0, 0, 0);
    send_move(5696, 0, 0, 0, 0);
    send_move(1, 0, 0, 0, 0);
    send_move(-1, 0, 0, 0, 0);
    send_move(-8000, 0, 0, 0, 0);
    send_move(-8192, 0, 0, 0, 0);
    send_move(8191, 64, 0, 0, 0);
    send_move(0, 5760, 0, 0, 0);
    send_move(0, -5760, 0, 0, 0);
    send_move(-5696, 11520 - 8192, 0, 0, 0);
    send_move(0, -1, 16'sh0001, 16'shffff, 16'sh8000);
    for (int i = 0; i < 260; i++)
      send_move(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_move(0, 0, 16'sh8000, 16'sh7fff, 16'sh8000);
    drain();

    // Limit above 90 degrees
    write_limit(13'd8191);
    send_move(8191, 0, 0, 0, 0);
    send_move(-8192, 100, 0, 0, 0);
    send_move(-8192, 0, 0, 0, 0);
    drain();

    // Random phases across limit settings
    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int i = 0; i < 275; i++) begin
        random_move(p != 3);
        if (p != 1) send_gap();
        if (i == 150) drain();
      end
      drain();
    end
    stim_done = 1;
  end

  // Result side
  initial begin
    pose_t got;
    out_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.pos = '{position_x, position_y, position_z};
        got.fwd = '{forward_x, forward_y, forward_z};
        got.rgt = '{right_x, right_y, right_z};
        got.upv = '{up_x, up_y, up_z};
        pose_sb.check_pose(got);
      end
      out_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 5 ? 0 : cycles[12]);
    end
  end

  // Watchdog and end of run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (pose_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pose_sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/eco_pkg.sv
hdl/euler_camera_orientation_core.sv
tb/sv/testbench.sv
